/* design/mp2d_pkg.sv */
// Shared types and constants for the streaming 2-D max-pooling core.
// No dependencies; imported by every module of the block except mp2d_vmem.
`default_nettype none

package mp2d_pkg;

   localparam int POS_W        = 14;    // signed row/column positions incl. padding
   localparam int ROW_W        = 10;    // input row counter
   localparam int IDX_W        = 11;    // output row/column index
   localparam int PLANE_W      = 16;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   typedef logic signed [POS_W-1:0] pos_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IN_HEIGHT     = 3'd0,
      REG_IN_WIDTH      = 3'd1,
      REG_KERNEL_SIZE   = 3'd2,
      REG_WINDOW_STRIDE = 3'd3,
      REG_PAD_AMOUNT    = 3'd4,
      REG_PLANE_COUNT   = 3'd5
   } csr_reg_type;

   // Clamped geometry, ready for the scanner
   typedef struct packed {
      pos_type            km1;      // kernel - 1
      logic [3:0]         stride;   // effective stride
      pos_type            pad;
      pos_type            h_m1;     // rows - 1
      pos_type            w_m1;     // columns - 1
      pos_type            h_lim;    // last row a window end may reach: rows - 1 + pad
      pos_type            w_lim;
      logic [PLANE_W-1:0] planes;
   } cfg_type;

   // Per-sample position flags handed from scanner to result stage
   typedef struct packed {
      logic             plane_end;
      logic             batch_end;
      logic             col_adv;
      logic [IDX_W-1:0] oh_base;
      logic [IDX_W-1:0] ow_base;
   } scan_type;

endpackage

`default_nettype wire

/* design/mp2d_cfg.sv */
// Configuration registers of the max-pooling core and their clamped geometry.
// Depends on mp2d_pkg.
`default_nettype none

module mp2d_cfg #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_KERNEL = 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mp2d_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mp2d_pkg::CSR_DATA_W-1:0]   csr_data,
   output mp2d_pkg::cfg_type                      cfg,
   output logic                                   cfg_wr
);
   import mp2d_pkg::*;

   logic [10:0] height_ff, width_ff;
   logic [3:0]  kernel_ff, stride_ff;
   logic [2:0]  pad_ff;
   logic [15:0] planes_ff;
   logic        hit;
   logic [3:0]  k_val, half_k, p_val;
   pos_type     h_pos, w_pos;

   assign csr_ready = 1'b1;

   always_comb begin
      unique case (csr_reg_type'(csr_index))
         REG_IN_HEIGHT, REG_IN_WIDTH, REG_KERNEL_SIZE,
         REG_WINDOW_STRIDE, REG_PAD_AMOUNT, REG_PLANE_COUNT: hit = 1'b1;
         default: hit = 1'b0;
      endcase
   end

   assign cfg_wr = csr_valid && hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= 11'd1;
         width_ff  <= 11'd1;
         kernel_ff <= 4'd2;
         stride_ff <= 4'd0;
         pad_ff    <= 3'd0;
         planes_ff <= 16'd1;
      end else if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_IN_HEIGHT:     height_ff <= csr_data[10:0];
            REG_IN_WIDTH:      width_ff  <= csr_data[10:0];
            REG_KERNEL_SIZE:   kernel_ff <= csr_data[3:0];
            REG_WINDOW_STRIDE: stride_ff <= csr_data[3:0];
            REG_PAD_AMOUNT:    pad_ff    <= csr_data[2:0];
            REG_PLANE_COUNT:   planes_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Clamp sizes into their legal ranges
   always_comb begin
      if (height_ff == '0)                      h_pos = pos_type'(1);
      else if (int'(height_ff) > HEIGHT_LIMIT)  h_pos = pos_type'(HEIGHT_LIMIT);
      else                                      h_pos = pos_type'(height_ff);
      if (width_ff == '0)                       w_pos = pos_type'(1);
      else if (int'(width_ff) > MAX_WIDTH)      w_pos = pos_type'(MAX_WIDTH);
      else                                      w_pos = pos_type'(width_ff);
      if (kernel_ff == '0)                      k_val = 4'd1;
      else if (int'(kernel_ff) > MAX_KERNEL)    k_val = 4'(MAX_KERNEL);
      else                                      k_val = kernel_ff;
      half_k = k_val >> 1;
      p_val  = ({1'b0, pad_ff} > half_k) ? half_k : {1'b0, pad_ff};
   end

   assign cfg.km1    = pos_type'(k_val) - pos_type'(1);
   assign cfg.stride = (stride_ff == '0) ? k_val : stride_ff;
   assign cfg.pad    = pos_type'(p_val);
   assign cfg.h_m1   = h_pos - pos_type'(1);
   assign cfg.w_m1   = w_pos - pos_type'(1);
   assign cfg.h_lim  = h_pos - pos_type'(1) + pos_type'(p_val);
   assign cfg.w_lim  = w_pos - pos_type'(1) + pos_type'(p_val);
   assign cfg.planes = (planes_ff == '0) ? 16'd1 : planes_ff;

endmodule

`default_nettype wire

/* design/mp2d_scan.sv */
// Raster position tracking: row/column/plane counters and the window lane masks.
// Depends on mp2d_pkg.
`default_nettype none

module mp2d_scan #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_KERNEL = 8
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire mp2d_pkg::cfg_type                          cfg,
   input  wire logic                                       cfg_wr,
   input  wire logic                                       accept,
   output logic [$clog2(MAX_WIDTH)-1:0]                    col_x,
   output logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] row_lane,
   output logic [MAX_KERNEL-1:0]                           in_r,
   output logic [MAX_KERNEL-1:0]                           beg_r,
   output logic [MAX_KERNEL-1:0]                           end_r,
   output logic [MAX_KERNEL-1:0]                           in_c,
   output logic [MAX_KERNEL-1:0]                           beg_c,
   output logic [MAX_KERNEL-1:0]                           end_c,
   output mp2d_pkg::scan_type                              info
);
   import mp2d_pkg::*;

   localparam int LW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int XW = $clog2(MAX_WIDTH);

   logic [XW-1:0]      x_ff;
   logic [ROW_W-1:0]   y_ff;
   logic [PLANE_W-1:0] plane_ff;
   logic [IDX_W-1:0]   oh_ff, ow_ff;
   pos_type            rofs_ff, cofs_ff;
   logic [LW-1:0]      lane_ff;

   pos_type x_pos, y_pos, rbase, cbase;
   logic    last_col, last_row, row_adv, col_adv, batch_last;

   assign x_pos      = pos_type'(x_ff);
   assign y_pos      = pos_type'(y_ff);
   assign rbase      = rofs_ff - cfg.pad;
   assign cbase      = cofs_ff - cfg.pad;
   assign last_col   = (x_pos == cfg.w_m1);
   assign last_row   = (y_pos == cfg.h_m1);
   assign row_adv    = ((rbase + cfg.km1) == y_pos);
   assign col_adv    = ((cbase + cfg.km1) == x_pos);
   assign batch_last = ({1'b0, plane_ff} + 17'd1) >= {1'b0, cfg.planes};

   // Lane j tracks the window base + j * stride in each direction
   always_comb begin
      pos_type off, rs, re, cs, ce;
      for (int j = 0; j < MAX_KERNEL; j++) begin
         off      = pos_type'(j) * pos_type'(cfg.stride);
         rs       = rbase + off;
         re       = rs + cfg.km1;
         cs       = cbase + off;
         ce       = cs + cfg.km1;
         in_r[j]  = (re <= cfg.h_lim) && (rs <= y_pos) && (y_pos <= re);
         beg_r[j] = (y_pos == (rs[POS_W-1] ? pos_type'(0) : rs));
         end_r[j] = in_r[j] && ((y_pos == re) || last_row);
         in_c[j]  = (ce <= cfg.w_lim) && (cs <= x_pos) && (x_pos <= ce);
         beg_c[j] = (x_pos == (cs[POS_W-1] ? pos_type'(0) : cs));
         end_c[j] = in_c[j] && ((x_pos == ce) || last_col);
      end
   end

   assign col_x          = x_ff;
   assign row_lane       = lane_ff;
   assign info.plane_end = last_row && last_col;
   assign info.batch_end = last_row && last_col && batch_last;
   assign info.col_adv   = col_adv && !last_col;
   assign info.oh_base   = oh_ff;
   assign info.ow_base   = ow_ff;

   always_ff @(posedge clock) begin
      if (reset || cfg_wr) begin
         x_ff     <= '0;
         y_ff     <= '0;
         plane_ff <= '0;
         oh_ff    <= '0;
         ow_ff    <= '0;
         rofs_ff  <= '0;
         cofs_ff  <= '0;
         lane_ff  <= '0;
      end else if (accept) begin
         if (last_col) begin
            x_ff    <= '0;
            ow_ff   <= '0;
            cofs_ff <= '0;
            if (last_row) begin
               y_ff     <= '0;
               oh_ff    <= '0;
               rofs_ff  <= '0;
               lane_ff  <= '0;
               plane_ff <= batch_last ? '0 : plane_ff + 1'b1;
            end else begin
               y_ff <= y_ff + 1'b1;
               if (row_adv) begin
                  oh_ff   <= oh_ff + 1'b1;
                  rofs_ff <= rofs_ff + pos_type'(cfg.stride);
                  lane_ff <= (lane_ff == LW'(MAX_KERNEL - 1)) ? '0 : lane_ff + 1'b1;
               end
            end
         end else begin
            x_ff <= x_ff + 1'b1;
            if (col_adv) begin
               ow_ff   <= ow_ff + 1'b1;
               cofs_ff <= cofs_ff + pos_type'(cfg.stride);
            end
         end
      end
   end

endmodule

`default_nettype wire

/* design/mp2d_vmem.sv */
// Column-maximum memory: one word per input column, one lane per open window row.
// Read at sample accept, written back by the result stage, with write-to-read forwarding.
`default_nettype none

module mp2d_vmem #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_KERNEL  = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 rd_en,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
   input  wire logic                                 wr_en,
   input  wire logic [MAX_KERNEL*SAMPLE_BITS-1:0]    wr_word,
   output logic [MAX_KERNEL*SAMPLE_BITS-1:0]         rd_word
);
   localparam int WORD_W = MAX_KERNEL * SAMPLE_BITS;
   localparam int AW     = $clog2(MAX_WIDTH);

   logic [WORD_W-1:0] mem [MAX_WIDTH];
   logic [WORD_W-1:0] rd_ff, fwd_word_ff;
   logic [AW-1:0]     addr_ff;
   logic              fwd_ff;

   // Write back to the address held for the item in flight
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr_ff] <= wr_word;
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         addr_ff     <= rd_addr;
         fwd_word_ff <= wr_word;
      end
   end

   // Same column written on the read edge: take the new word instead
   always_ff @(posedge clock) begin
      if (reset)      fwd_ff <= 1'b0;
      else if (rd_en) fwd_ff <= wr_en && (addr_ff == rd_addr);
   end

   assign rd_word = fwd_ff ? fwd_word_ff : rd_ff;

endmodule

`default_nettype wire

/* design/mp2d_emit.sv */
// Result stage: column-max update, row-window accumulators, result walk and output queue.
// Depends on mp2d_pkg; fed by mp2d_scan and mp2d_vmem.
`default_nettype none

module mp2d_emit #(
   parameter int MAX_KERNEL  = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       accept,
   input  wire logic signed [SAMPLE_BITS-1:0]              sample,
   input  wire logic [MAX_KERNEL-1:0]                      in_r,
   input  wire logic [MAX_KERNEL-1:0]                      beg_r,
   input  wire logic [MAX_KERNEL-1:0]                      end_r,
   input  wire logic [MAX_KERNEL-1:0]                      in_c,
   input  wire logic [MAX_KERNEL-1:0]                      beg_c,
   input  wire logic [MAX_KERNEL-1:0]                      end_c,
   input  wire logic [((MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1)-1:0] row_lane,
   input  wire mp2d_pkg::scan_type                         info,
   input  wire logic [MAX_KERNEL*SAMPLE_BITS-1:0]          rd_word,
   output logic                                            up_ready,
   output logic                                            wr_en,
   output logic [MAX_KERNEL*SAMPLE_BITS-1:0]               wr_word,
   output logic                                            rsp_valid,
   input  wire logic                                       rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]                   pooled_value,
   output logic [mp2d_pkg::IDX_W-1:0]                      out_row,
   output logic [mp2d_pkg::IDX_W-1:0]                      out_col,
   output logic                                            last_of_run,
   output logic                                            plane_done,
   output logic                                            batch_done
);
   import mp2d_pkg::*;

   localparam int L     = MAX_KERNEL;
   localparam int SB    = SAMPLE_BITS;
   localparam int LW    = (L > 1) ? $clog2(L) : 1;
   localparam int ENT_W = SB + 2 * IDX_W + 3;

   function automatic logic [LW-1:0] lane_add(input logic [LW-1:0] a, input logic [LW-1:0] b);
      logic [LW:0] t;
      t = {1'b0, a} + {1'b0, b};
      if (t >= (LW+1)'(L)) t = t - (LW+1)'(L);
      return t[LW-1:0];
   endfunction

   // Item in flight
   logic                 s1_ff;
   logic signed [SB-1:0] sample_ff;
   logic [L-1:0]         inr_ff, begr_ff, endr_ff, inc_ff, begc_ff, endc_ff;
   logic [L-1:0]         rr_ff, cr_ff, rr_in, cr_in;
   logic [LW-1:0]        lane_ff;
   scan_type             info_ff;
   logic signed [SB-1:0] h_ff [L][L];

   // Output queue
   logic [1:0]       q_cnt_ff;
   logic [ENT_W-1:0] q0_ff, q1_ff;

   logic signed [SB-1:0] old_v [L];
   logic signed [SB-1:0] new_v [L];
   logic signed [SB-1:0] vrel  [L];
   logic signed [SB-1:0] hn    [L][L];
   logic [LW-1:0]        neg_lane, jr_sel, jc_sel;
   logic [L-1:0]         rr_rest, cr_rest;
   logic                 push, pop, fin, run_last;
   logic [ENT_W-1:0]     entry;

   assign neg_lane = LW'((LW+1)'(L) - {1'b0, lane_ff});

   // Read-modify-write of the column maxima, physical lane order
   always_comb begin
      logic [LW-1:0] jr;
      for (int p = 0; p < L; p++) begin
         old_v[p] = rd_word[p*SB +: SB];
         jr       = lane_add(LW'(p), neg_lane);
         if (!inr_ff[jr])     new_v[p] = old_v[p];
         else if (begr_ff[jr]) new_v[p] = sample_ff;
         else                 new_v[p] = (old_v[p] > sample_ff) ? old_v[p] : sample_ff;
         wr_word[p*SB +: SB] = new_v[p];
      end
   end

   always_comb begin
      for (int j = 0; j < L; j++) vrel[j] = new_v[lane_add(lane_ff, LW'(j))];
   end

   // Row-window maxima along the ending row, including this sample
   always_comb begin
      for (int jr = 0; jr < L; jr++) begin
         for (int jc = 0; jc < L; jc++) begin
            if (endr_ff[jr] && inc_ff[jc]) begin
               if (begc_ff[jc]) hn[jr][jc] = vrel[jr];
               else hn[jr][jc] = (h_ff[jr][jc] > vrel[jr]) ? h_ff[jr][jc] : vrel[jr];
            end else begin
               hn[jr][jc] = h_ff[jr][jc];
            end
         end
      end
   end

   // Lowest pending window row and column
   always_comb begin
      jr_sel = '0;
      jc_sel = '0;
      for (int j = L - 1; j >= 0; j--) begin
         if (rr_ff[j]) jr_sel = LW'(j);
         if (cr_ff[j]) jc_sel = LW'(j);
      end
      rr_rest = rr_ff & ~(L'(1) << jr_sel);
      cr_rest = cr_ff & ~(L'(1) << jc_sel);
   end

   assign run_last = (rr_rest == '0) && (cr_rest == '0);
   assign push     = s1_ff && (rr_ff != '0) && (q_cnt_ff != 2'd2);
   assign fin      = s1_ff && ((rr_ff == '0) || (push && run_last));
   assign up_ready = !s1_ff || fin;
   assign wr_en    = fin;
   assign pop      = (q_cnt_ff != 2'd0) && rsp_ready;

   assign entry = {run_last && info_ff.batch_end, run_last && info_ff.plane_end, run_last,
                   info_ff.ow_base + IDX_W'(jc_sel), info_ff.oh_base + IDX_W'(jr_sel),
                   hn[jr_sel][jc_sel]};

   always_comb begin
      rr_in = rr_ff;
      cr_in = cr_ff;
      if (accept) begin
         rr_in = (end_c != '0) ? end_r : '0;
         cr_in = end_c;
      end else if (push) begin
         if (cr_rest == '0) begin
            rr_in = rr_rest;
            cr_in = endc_ff;
         end else begin
            cr_in = cr_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff    <= 1'b0;
         rr_ff    <= '0;
         cr_ff    <= '0;
         q_cnt_ff <= 2'd0;
      end else begin
         if (accept)   s1_ff <= 1'b1;
         else if (fin) s1_ff <= 1'b0;
         rr_ff <= rr_in;
         cr_ff <= cr_in;
         unique case ({push, pop})
            2'b10:   q_cnt_ff <= q_cnt_ff + 2'd1;
            2'b01:   q_cnt_ff <= q_cnt_ff - 2'd1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= sample;
         inr_ff    <= in_r;
         begr_ff   <= beg_r;
         endr_ff   <= end_r;
         inc_ff    <= in_c;
         begc_ff   <= beg_c;
         endc_ff   <= end_c;
         lane_ff   <= row_lane;
         info_ff   <= info;
      end
      // Slide the column frame when the oldest column window closes
      if (fin) begin
         for (int jr = 0; jr < L; jr++) begin
            for (int jc = 0; jc < L; jc++) begin
               h_ff[jr][jc] <= (info_ff.col_adv && jc != L - 1) ?
                               hn[jr][(jc + 1) % L] : hn[jr][jc];
            end
         end
      end
      unique case ({push, pop})
         2'b10: begin
            if (q_cnt_ff == 2'd0) q0_ff <= entry;
            else                  q1_ff <= entry;
         end
         2'b01:   q0_ff <= q1_ff;
         2'b11:   q0_ff <= entry;
         default: ;
      endcase
   end

   assign rsp_valid    = (q_cnt_ff != 2'd0);
   assign pooled_value = q0_ff[SB-1:0];
   assign out_row      = q0_ff[SB +: IDX_W];
   assign out_col      = q0_ff[SB+IDX_W +: IDX_W];
   assign last_of_run  = q0_ff[SB+2*IDX_W];
   assign plane_done   = q0_ff[SB+2*IDX_W+1];
   assign batch_done   = q0_ff[SB+2*IDX_W+2];

endmodule

`default_nettype wire

/* design/max_pool_2d_stream_core.sv */
// Streaming 2-D max pooling. Samples of one plane after another arrive in raster order
// on req_*, one transaction per sample; each pooled window leaves on rsp_* tagged with its
// output row and column as soon as its bottom-right real sample has arrived. The core takes
// one sample per clock unless the result stage is still busy with an earlier sample. A sample
// that closes n windows (n > 1 only at the right and bottom borders) holds the result stage
// until its n results are queued, one result per cycle through the single write port of the
// two-entry output queue while it has room. Results within one sample come out by output
// row, then output column. Window state lives in a column-maximum memory of MAX_WIDTH words
// (one lane per open window row), read when a sample is taken and written back in the cycle
// its last result is queued; no clearing pass is needed since each window lane starts fresh
// on its first row. Any register write restarts the batch at row 0, column 0, plane 0.
// Registers must be written only while the core is idle.
`default_nettype none

module max_pool_2d_stream_core #(
   parameter int MAX_WIDTH   = 1024,
   parameter int MAX_KERNEL  = 8,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // sample stream
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,  // [0+]: sample
   // result stream
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [((SAMPLE_BITS+29)/8)*8-1:0]          rsp_tdata,  // pooled_value, out_row, out_col
   output logic                                       rsp_tlast,  // last_of_run
   output logic [1:0]                                 rsp_tuser,  // plane_done, batch_done
   // register writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mp2d_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [mp2d_pkg::CSR_DATA_W-1:0]       csr_data
);
   import mp2d_pkg::*;

   localparam int LW    = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int RSP_W = ((SAMPLE_BITS + 29) / 8) * 8;

   cfg_type  cfg;
   scan_type info;
   logic     cfg_wr, accept, rsp_v, wr_en;
   logic [XW-1:0]                       col_x;
   logic [LW-1:0]                       row_lane;
   logic [MAX_KERNEL-1:0]               in_r, beg_r, end_r, in_c, beg_c, end_c;
   logic [MAX_KERNEL*SAMPLE_BITS-1:0]   rd_word, wr_word;
   logic signed [SAMPLE_BITS-1:0]       pooled_value;
   logic [IDX_W-1:0]                    out_row, out_col;
   logic                                last_of_run, plane_done, batch_done;

   // A transaction on the sample side enters the scanner and the memory read together
   assign accept = req_tvalid && req_tready;

   mp2d_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_cfg (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .cfg, .cfg_wr
   );

   mp2d_scan #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL)) u_scan (
      .clock, .reset, .cfg, .cfg_wr, .accept, .col_x, .row_lane,
      .in_r, .beg_r, .end_r, .in_c, .beg_c, .end_c, .info
   );

   mp2d_vmem #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL), .SAMPLE_BITS(SAMPLE_BITS)) u_vmem (
      .clock, .reset, .rd_en(accept), .rd_addr(col_x), .wr_en, .wr_word, .rd_word
   );

   mp2d_emit #(.MAX_KERNEL(MAX_KERNEL), .SAMPLE_BITS(SAMPLE_BITS)) u_emit (
      .clock, .reset, .accept, .sample(req_tdata[SAMPLE_BITS-1:0]),
      .in_r, .beg_r, .end_r, .in_c, .beg_c, .end_c, .row_lane, .info, .rd_word,
      .up_ready(req_tready), .wr_en, .wr_word,
      .rsp_valid(rsp_v), .rsp_ready(rsp_tready),
      .pooled_value, .out_row, .out_col, .last_of_run, .plane_done, .batch_done
   );

   // Pack result fields, lowest first, zero-filled to whole bytes
   assign rsp_tvalid = rsp_v;
   assign rsp_tdata  = RSP_W'({out_col, out_row, pooled_value});
   assign rsp_tlast  = last_of_run;
   assign rsp_tuser  = {batch_done, plane_done};

`ifndef SYNTHESIS
   // End of batch is always also end of plane and end of the sample's run
   a_done_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && rsp_tlast)
      else $error("batch_done without plane_done and tlast");

   // A register write restarts the raster at column 0 and the first window lane
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (col_x == '0) && (row_lane == '0))
      else $error("scan position not restarted after register write");
`endif

endmodule

`default_nettype wire
